### sv/scpci_pkg.sv
// Shared types, widths and constants for the sin*cos cell integral block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package scpci_pkg;

    // Counts and widths fixed by the field formats
    localparam int MAX_COUNT        = 64;
    localparam int CORDIC_STEPS_DEF = 28;
    localparam int U_W    = 34;   // grid point, Q7.24 with headroom for u0+2*du
    localparam int K_W    = 34;   // frequency sum or difference, Q15.16
    localparam int KM_W   = 33;   // magnitude of k
    localparam int CD_W   = 33;   // saturated cosine difference, Q30
    localparam int D_W    = 36;   // 2*cos(k*du), Q30
    localparam int CS_W   = 34;   // CORDIC x/y/z
    localparam int LIMB_W = 34;
    localparam int MUL_W  = 2 * LIMB_W;
    localparam int ACC_W  = 2 * MUL_W;
    localparam int DIVN_W = 49;   // |c| << 17
    localparam int DIVD_W = 33;   // |k|
    localparam int TERM_W = DIVN_W + 1;
    localparam int SUM_W  = TERM_W + 1;
    localparam int OUT_W  = 48;
    localparam int CNT_W  = 7;
    localparam int IDX_W  = 6;
    localparam int THR_W  = 31;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [61:0] INV_TWO_PI  = 62'h28BE60DB9391054A;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic signed [CS_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [39:0] DIFF_LIMIT = 40'sd2147483648;
    localparam logic signed [SUM_W-1:0] OUT_MAX = 51'sd140737488355327;
    localparam logic signed [SUM_W-1:0] OUT_MIN = -51'sd140737488355328;
    localparam logic [THR_W-1:0] THR_RESET = 31'd7;

    // Register index (byte address / 4)
    localparam logic REG_NEAR_THR = 1'b0;

    typedef struct packed {
        logic signed [31:0] start_point;
        logic signed [31:0] step_size;
        logic [6:0]         cell_count;
        logic signed [31:0] cos_frequency;
        logic signed [31:0] sin_frequency;
    } req_t;

    typedef struct packed {
        logic signed [47:0] integral_value;
        logic [5:0]         cell_index;
        logic               last_cell;
    } rsp_t;

    typedef enum logic [1:0] {
        MS_PHASE_A,  // |k| * |u|
        MS_PHASE_B,  // previous product * 1/(2*pi)
        MS_ANGLE,    // quadrant fraction * pi/2
        MS_REC       // |d| * |c1|
    } mul_sel_t;

    typedef enum logic [1:0] {
        UP_U0,
        UP_U1,
        UP_U2,
        UP_DU
    } upos_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL_K,
        ST_WAIT_K,
        ST_MUL_C,
        ST_WAIT_C,
        ST_MUL_A,
        ST_WAIT_A,
        ST_CORD,
        ST_WAIT_CORD,
        ST_CELL,
        ST_REC_MUL,
        ST_REC_WAIT,
        ST_REC_UPD,
        ST_DIV,
        ST_DIV_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic        load_req;
        logic        prep;
        logic        mul_start;
        mul_sel_t    mul_sel;
        logic        cord_start;
        logic        store_cos;
        logic        rec_update;
        logic        div_start;
        logic        div_use_c0;
        logic        sum_clear;
        logic        sum_add;
        logic        out_load;
        logic        term;
        upos_t       upos;
        logic [IDX_W-1:0] cell_idx;
        logic        last;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0]       nterms;
        logic [CNT_W-1:0] count;
        logic             mul_busy;
        logic             cord_busy;
        logic             div_busy;
        logic             out_free;
    } dp_stat_t;

    function automatic logic [30:0] atan_q30(input logic [5:0] i);
        logic [30:0] v;
        v = '0;
        unique case (i)
            6'd0: v = 31'd843314857;
            6'd1: v = 31'd497837829;
            6'd2: v = 31'd263043837;
            6'd3: v = 31'd133525159;
            6'd4: v = 31'd67021687;
            6'd5: v = 31'd33543516;
            6'd6: v = 31'd16775851;
            6'd7: v = 31'd8388437;
            6'd8: v = 31'd4194283;
            6'd9: v = 31'd2097149;
            default:
            begin
                if (i <= 6'd30)
                begin
                    v = 31'd1 << (6'd30 - i);
                end
            end
        endcase
        return v;
    endfunction

    function automatic logic signed [CD_W-1:0] sat_diff(input logic signed [39:0] v);
        logic signed [CD_W-1:0] r;
        if (v > DIFF_LIMIT)
        begin
            r = CD_W'(DIFF_LIMIT);
        end
        else if (v < -DIFF_LIMIT)
        begin
            r = CD_W'(-DIFF_LIMIT);
        end
        else
        begin
            r = v[CD_W-1:0];
        end
        return r;
    endfunction

endpackage

### sv/scpci_mul.sv
// Multi-cycle unsigned multiplier: four 34x34 partial products, registered, then accumulated.
// Depends on scpci_pkg.
`timescale 1ns / 1ps

module scpci_mul
    import scpci_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [MUL_W-1:0] a,
    input  logic [MUL_W-1:0] b,
    output logic             busy,
    output logic [ACC_W-1:0] prod
);

    logic [MUL_W-1:0]  a_reg, a_next, b_reg, b_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [MUL_W-1:0]  pp_reg, pp_next;
    logic [1:0]        sh_reg, sh_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [LIMB_W-1:0] a_limb, b_limb;
    logic [ACC_W-1:0]  acc_add;

    always_comb
    begin
        a_limb  = cnt_reg[1] ? a_reg[MUL_W-1:LIMB_W] : a_reg[LIMB_W-1:0];
        b_limb  = cnt_reg[0] ? b_reg[MUL_W-1:LIMB_W] : b_reg[LIMB_W-1:0];
        acc_add = ACC_W'(pp_reg) << (LIMB_W * sh_reg);

        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        pp_next   = pp_reg;
        sh_next   = sh_reg;
        acc_next  = acc_reg;

        if (start)
        begin
            a_next    = a;
            b_next    = b;
            cnt_next  = '0;
            busy_next = 1'b1;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 3'd0)
            begin
                acc_next = acc_reg + acc_add;
            end
            if (cnt_reg == 3'd4)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pp_next  = a_limb * b_limb;
                sh_next  = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                cnt_next = cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        pp_reg  <= pp_next;
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
    end

    assign busy = busy_reg;
    assign prod = acc_reg;

endmodule

### sv/scpci_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on scpci_pkg (arctangent table, widths).
`timescale 1ns / 1ps

module scpci_cordic
    import scpci_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [30:0]            z0,
    output logic                   busy,
    output logic signed [CS_W-1:0] x,
    output logic signed [CS_W-1:0] y
);

    localparam int IT_W = $clog2(CORDIC_STEPS);

    logic signed [CS_W-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [IT_W-1:0]        it_reg, it_next;
    logic                   busy_reg, busy_next;
    logic signed [CS_W-1:0] dx, dy, ang;

    always_comb
    begin
        dx  = y_reg >>> it_reg;
        dy  = x_reg >>> it_reg;
        ang = $signed(CS_W'(atan_q30(6'(it_reg))));

        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        it_next   = it_reg;
        busy_next = busy_reg;

        if (start)
        begin
            x_next    = CORDIC_GAIN_Q30;
            y_next    = '0;
            z_next    = $signed(CS_W'(z0));
            it_next   = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!z_reg[CS_W-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - ang;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + ang;
            end
            if (it_reg == IT_W'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
            end
            else
            begin
                it_next = it_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            it_reg   <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign busy = busy_reg;
    assign x    = x_reg;
    assign y    = y_reg;

endmodule

### sv/scpci_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, signed result by flag.
// Depends on scpci_pkg.
`timescale 1ns / 1ps

module scpci_div
    import scpci_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVN_W-1:0]        num,
    input  logic [DIVD_W-1:0]        den,
    input  logic                     neg,
    output logic                     busy,
    output logic signed [TERM_W-1:0] quo
);

    logic [DIVD_W-1:0] rem_reg, rem_next, den_reg, den_next;
    logic [DIVN_W-1:0] q_reg, q_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              neg_reg, neg_next, zero_reg, zero_next;
    logic [DIVD_W:0]   trial;
    logic              ge;

    always_comb
    begin
        trial = {rem_reg, q_reg[DIVN_W-1]};
        ge    = trial >= {1'b0, den_reg};

        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;

        if (start)
        begin
            rem_next  = '0;
            den_next  = den;
            q_next    = num;
            cnt_next  = '0;
            busy_next = 1'b1;
            neg_next  = neg;
            zero_next = (den == '0);
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DIVD_W'(trial - {1'b0, den_reg}) : trial[DIVD_W-1:0];
            q_next   = {q_reg[DIVN_W-2:0], ge};
            if (cnt_reg == 6'(DIVN_W - 1))
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + 6'd1;
            end
        end

        // a zero divisor contributes nothing
        if (zero_reg)
        begin
            quo = '0;
        end
        else if (neg_reg)
        begin
            quo = -$signed({1'b0, q_reg});
        end
        else
        begin
            quo = $signed({1'b0, q_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        q_reg    <= q_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    assign busy = busy_reg;

endmodule

### sv/scpci_datapath.sv
// Datapath: request registers, term state, shared multiplier, CORDIC, divider, result register.
// Depends on scpci_pkg, scpci_mul, scpci_cordic, scpci_div.
`timescale 1ns / 1ps

module scpci_datapath
    import scpci_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  req_t             req,
    input  logic [THR_W-1:0] thr,
    input  dp_cmd_t          cmd,
    output dp_stat_t         stat,
    input  logic             rsp_ready,
    output logic             rsp_valid,
    output rsp_t             rsp
);

    req_t                   req_reg, req_next;
    logic signed [U_W-1:0]  u1_reg, u1_next, u2_reg, u2_next;
    logic signed [K_W-1:0]  k_reg [2], k_next [2];
    logic signed [CD_W-1:0] c0_reg [2], c0_next [2], c1_reg [2], c1_next [2];
    logic signed [D_W-1:0]  d_reg [2], d_next [2];
    logic signed [CS_W-1:0] ca_reg, ca_next, cb_reg, cb_next;
    logic [1:0]             quad_reg, quad_next;
    logic                   rneg_reg, rneg_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    rsp_t                   out_reg, out_next;
    logic                   outv_reg, outv_next;

    logic signed [U_W-1:0]  u0_s, du_s, u_sel, uabs;
    logic signed [32:0]     a1_x, a2_x;
    logic [32:0]            m1, m2;
    logic signed [33:0]     mdiff, adiff;
    logic                   near_zero, near_eq;
    logic [1:0]             nterms;
    logic [CNT_W-1:0]       n_sat;
    logic signed [K_W-1:0]  k_sel, kabs;
    logic [KM_W-1:0]        kmag;
    logic signed [D_W-1:0]  d_sel, dabs;
    logic signed [CD_W-1:0] c0_sel, c1_sel, c1abs, v_sel, vabs;
    logic [MUL_W-1:0]       mul_a, mul_b;
    logic                   mul_busy, cord_busy, div_busy;
    logic [ACC_W-1:0]       prod;
    logic signed [CS_W-1:0] cx, cy, cos_val;
    logic signed [MUL_W:0]  rec_p;
    logic signed [38:0]     rec_sh;
    logic signed [CD_W-1:0] rec_v;
    logic signed [TERM_W-1:0] div_q;
    logic [DIVN_W-1:0]      div_num;
    logic signed [OUT_W-1:0] sum_sat;

    scpci_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .prod  (prod)
    );

    scpci_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.cord_start),
        .z0    (prod[60:30]),
        .busy  (cord_busy),
        .x     (cx),
        .y     (cy)
    );

    scpci_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (kmag),
        .neg   (v_sel[CD_W-1] == k_sel[K_W-1]),
        .busy  (div_busy),
        .quo   (div_q)
    );

    // Case selection and per-request constants
    always_comb
    begin
        u0_s  = {{2{req_reg.start_point[31]}}, req_reg.start_point};
        du_s  = {{2{req_reg.step_size[31]}}, req_reg.step_size};
        a1_x  = {req_reg.cos_frequency[31], req_reg.cos_frequency};
        a2_x  = {req_reg.sin_frequency[31], req_reg.sin_frequency};
        m1    = a1_x[32] ? 33'(-a1_x) : 33'(a1_x);
        m2    = a2_x[32] ? 33'(-a2_x) : 33'(a2_x);
        mdiff = $signed({1'b0, m1}) - $signed({1'b0, m2});
        adiff = mdiff[33] ? -mdiff : mdiff;
        near_zero = m2 <= {2'b00, thr};
        near_eq   = 34'(adiff) <= {3'b000, thr};
        if (near_zero)
        begin
            nterms = 2'd0;
        end
        else if (near_eq)
        begin
            nterms = 2'd1;
        end
        else
        begin
            nterms = 2'd2;
        end
        n_sat = (req_reg.cell_count > CNT_W'(MAX_COUNT)) ? CNT_W'(MAX_COUNT)
                                                         : req_reg.cell_count;
    end

    // Operand selection for the current term and grid point
    always_comb
    begin
        k_sel  = k_reg[cmd.term];
        kabs   = k_sel[K_W-1] ? -k_sel : k_sel;
        kmag   = kabs[KM_W-1:0];
        d_sel  = d_reg[cmd.term];
        dabs   = d_sel[D_W-1] ? -d_sel : d_sel;
        c0_sel = c0_reg[cmd.term];
        c1_sel = c1_reg[cmd.term];
        c1abs  = c1_sel[CD_W-1] ? -c1_sel : c1_sel;
        v_sel  = cmd.div_use_c0 ? c0_sel : c1_sel;
        vabs   = v_sel[CD_W-1] ? -v_sel : v_sel;
        div_num = {vabs[31:0], 17'd0};

        unique case (cmd.upos)
            UP_U0: u_sel = u0_s;
            UP_U1: u_sel = u1_reg;
            UP_U2: u_sel = u2_reg;
            UP_DU: u_sel = du_s;
        endcase
        uabs = u_sel[U_W-1] ? -u_sel : u_sel;

        unique case (cmd.mul_sel)
            MS_PHASE_A:
            begin
                mul_a = MUL_W'(kmag);
                mul_b = MUL_W'(uabs);
            end
            MS_PHASE_B:
            begin
                mul_a = prod[MUL_W-1:0];
                mul_b = MUL_W'(INV_TWO_PI);
            end
            MS_ANGLE:
            begin
                mul_a = MUL_W'(prod[101:72]);
                mul_b = MUL_W'(HALF_PI_Q30);
            end
            MS_REC:
            begin
                mul_a = MUL_W'(dabs);
                mul_b = MUL_W'(c1abs);
            end
        endcase

        unique case (quad_reg)
            2'd0: cos_val = cx;
            2'd1: cos_val = -cy;
            2'd2: cos_val = -cx;
            2'd3: cos_val = cy;
        endcase

        // recurrence: floor((d*c1) / 2^30) - c0, saturated
        rec_p  = rneg_reg ? -$signed({1'b0, prod[MUL_W-1:0]})
                          : $signed({1'b0, prod[MUL_W-1:0]});
        rec_sh = 39'(rec_p >>> 30);
        rec_v  = sat_diff(40'(rec_sh) - 40'(c0_sel));

        if (sum_reg > OUT_MAX)
        begin
            sum_sat = OUT_W'(OUT_MAX);
        end
        else if (sum_reg < OUT_MIN)
        begin
            sum_sat = OUT_W'(OUT_MIN);
        end
        else
        begin
            sum_sat = sum_reg[OUT_W-1:0];
        end
    end

    // Register updates
    always_comb
    begin
        req_next  = req_reg;
        u1_next   = u1_reg;
        u2_next   = u2_reg;
        k_next    = k_reg;
        c0_next   = c0_reg;
        c1_next   = c1_reg;
        d_next    = d_reg;
        ca_next   = ca_reg;
        cb_next   = cb_reg;
        quad_next = quad_reg;
        rneg_next = rneg_reg;
        sum_next  = sum_reg;
        out_next  = out_reg;
        outv_next = outv_reg;

        if (cmd.load_req)
        begin
            req_next = req;
        end
        if (cmd.prep)
        begin
            u1_next = u0_s + du_s;
            u2_next = u0_s + (du_s <<< 1);
            if (nterms == 2'd1)
            begin
                k_next[0] = {a2_x, 1'b0};
            end
            else
            begin
                k_next[0] = K_W'(a2_x) - K_W'(a1_x);
            end
            k_next[1] = K_W'(a2_x) + K_W'(a1_x);
        end
        if (cmd.mul_start && cmd.mul_sel == MS_ANGLE)
        begin
            quad_next = prod[103:102];
        end
        if (cmd.mul_start && cmd.mul_sel == MS_REC)
        begin
            rneg_next = d_sel[D_W-1] ^ c1_sel[CD_W-1];
        end
        if (cmd.store_cos)
        begin
            unique case (cmd.upos)
                UP_U0: ca_next = cos_val;
                UP_U1: cb_next = cos_val;
                UP_U2:
                begin
                    c0_next[cmd.term] = sat_diff(40'(cb_reg) - 40'(ca_reg));
                    c1_next[cmd.term] = sat_diff(40'(cos_val) - 40'(cb_reg));
                end
                UP_DU: d_next[cmd.term] = $signed({cos_val[CS_W-1], cos_val, 1'b0});
            endcase
        end
        if (cmd.rec_update)
        begin
            c0_next[cmd.term] = c1_sel;
            c1_next[cmd.term] = rec_v;
        end
        if (cmd.sum_clear)
        begin
            sum_next = '0;
        end
        else if (cmd.sum_add)
        begin
            sum_next = sum_reg + SUM_W'(div_q);
        end

        if (cmd.out_load)
        begin
            out_next.integral_value = sum_sat;
            out_next.cell_index     = cmd.cell_idx;
            out_next.last_cell      = cmd.last;
            outv_next               = 1'b1;
        end
        else if (rsp_ready)
        begin
            outv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outv_reg <= 1'b0;
        end
        else
        begin
            outv_reg <= outv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        u1_reg   <= u1_next;
        u2_reg   <= u2_next;
        k_reg    <= k_next;
        c0_reg   <= c0_next;
        c1_reg   <= c1_next;
        d_reg    <= d_next;
        ca_reg   <= ca_next;
        cb_reg   <= cb_next;
        quad_reg <= quad_next;
        rneg_reg <= rneg_next;
        sum_reg  <= sum_next;
        out_reg  <= out_next;
    end

    always_comb
    begin
        stat.nterms    = nterms;
        stat.count     = n_sat;
        stat.mul_busy  = mul_busy;
        stat.cord_busy = cord_busy;
        stat.div_busy  = div_busy;
        stat.out_free  = !outv_reg || rsp_ready;
    end

    assign rsp_valid = outv_reg;
    assign rsp       = out_reg;

endmodule

### sv/scpci_ctrl.sv
// Sequencer: walks cosine setup for each term, then the per-cell recurrence and division.
// Depends on scpci_pkg.
`timescale 1ns / 1ps

module scpci_ctrl
    import scpci_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t           state_reg, state_next;
    logic             term_reg, term_next;
    upos_t            upos_reg, upos_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic             last_term, rec_needed, last_cell;

    always_comb
    begin
        last_term  = (stat.nterms == 2'd1) || term_reg;
        rec_needed = j_reg >= CNT_W'(2);
        last_cell  = (j_reg + CNT_W'(1)) == stat.count;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        upos_next  = upos_reg;
        j_next     = j_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                term_next = 1'b0;
                upos_next = UP_U0;
                j_next    = '0;
                if (stat.count == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.nterms == 2'd0)
                begin
                    state_next = ST_CELL;
                end
                else
                begin
                    state_next = ST_MUL_K;
                end
            end
            ST_MUL_K:  state_next = ST_WAIT_K;
            ST_WAIT_K:
            begin
                if (!stat.mul_busy)
                begin
                    state_next = ST_MUL_C;
                end
            end
            ST_MUL_C:  state_next = ST_WAIT_C;
            ST_WAIT_C:
            begin
                if (!stat.mul_busy)
                begin
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A:  state_next = ST_WAIT_A;
            ST_WAIT_A:
            begin
                if (!stat.mul_busy)
                begin
                    state_next = ST_CORD;
                end
            end
            ST_CORD:   state_next = ST_WAIT_CORD;
            ST_WAIT_CORD:
            begin
                if (!stat.cord_busy)
                begin
                    state_next = ST_MUL_K;
                    if (upos_reg == UP_DU)
                    begin
                        upos_next = UP_U0;
                        if (last_term)
                        begin
                            term_next  = 1'b0;
                            state_next = ST_CELL;
                        end
                        else
                        begin
                            term_next = 1'b1;
                        end
                    end
                    else
                    begin
                        upos_next = upos_t'(upos_reg + 2'd1);
                    end
                end
            end
            ST_CELL:
            begin
                term_next = 1'b0;
                if (stat.nterms == 2'd0)
                begin
                    state_next = ST_EMIT;
                end
                else if (rec_needed)
                begin
                    state_next = ST_REC_MUL;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_REC_MUL: state_next = ST_REC_WAIT;
            ST_REC_WAIT:
            begin
                if (!stat.mul_busy)
                begin
                    state_next = ST_REC_UPD;
                end
            end
            ST_REC_UPD: state_next = ST_DIV;
            ST_DIV:     state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    if (last_term)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        term_next  = 1'b1;
                        state_next = rec_needed ? ST_REC_MUL : ST_DIV;
                    end
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    if (last_cell)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + CNT_W'(1);
                        state_next = ST_CELL;
                    end
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd          = '0;
        cmd.mul_sel  = MS_PHASE_A;
        cmd.term     = term_reg;
        cmd.upos     = upos_reg;
        cmd.cell_idx = j_reg[IDX_W-1:0];
        cmd.last     = last_cell;
        cmd.div_use_c0 = (j_reg == '0);
        req_ready    = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:      cmd.load_req = req_valid;
            ST_LOAD:      cmd.prep = 1'b1;
            ST_MUL_K:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_PHASE_A;
            end
            ST_MUL_C:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_PHASE_B;
            end
            ST_MUL_A:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_ANGLE;
            end
            ST_CORD:      cmd.cord_start = 1'b1;
            ST_WAIT_CORD: cmd.store_cos = !stat.cord_busy;
            ST_CELL:      cmd.sum_clear = 1'b1;
            ST_REC_MUL:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_REC;
            end
            ST_REC_UPD:   cmd.rec_update = 1'b1;
            ST_DIV:       cmd.div_start = 1'b1;
            ST_DIV_WAIT:  cmd.sum_add = !stat.div_busy;
            ST_EMIT:      cmd.out_load = stat.out_free;
            default:      cmd.prep = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            term_reg  <= 1'b0;
            upos_reg  <= UP_U0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
            upos_reg  <= upos_next;
            j_reg     <= j_next;
        end
    end

endmodule

### sv/sin_cos_product_cell_integrals_top.sv
// Top level of the sin(a2*u)*cos(a1*u) cell integral block: config register and wiring.
// Depends on scpci_pkg, scpci_ctrl, scpci_datapath.
`timescale 1ns / 1ps

//  port group | handshake                    | payload
//  -----------+------------------------------+--------------------------------------
//  request    | req_valid / req_ready        | req  (req_t: u0, du, count, a1, a2)
//  result     | rsp_valid / rsp_ready        | rsp  (rsp_t: integral, index, last)
//  config     | psel/penable/pwrite, pready  | paddr, pwdata, prdata (near_threshold)
//
// One request at a time. Setup computes four cosines per term, T being the term count
// (0, 1 or 2): each cosine takes three passes through the shared multiplier (four 34x34
// partial products each) plus one CORDIC run. Each cell then runs the divider once per
// term, plus one recurrence multiply per term from the third cell on.
// Reset is asynchronous, active low; it restores near_threshold to 7 and empties the result
// register. A stalled result holds in its register; the sequencer waits before overwriting.

module sin_cos_product_cell_integrals_top
    import scpci_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rsp_t              rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [THR_W-1:0] thr_reg, thr_next;
    logic             reg_sel;
    dp_cmd_t          cmd;
    dp_stat_t         stat;

    // Register index is the word address; only near_threshold exists.
    assign reg_sel = paddr[ADDR_W-1];

    always_comb
    begin
        thr_next = thr_reg;
        if (psel && penable && pwrite && reg_sel == REG_NEAR_THR)
        begin
            thr_next = pwdata[THR_W-1:0];
        end
        prdata = (reg_sel == REG_NEAR_THR) ? DATA_W'(thr_reg) : '0;
    end

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    // Sequencer: accepts a request when idle, steps the datapath through setup and cells
    scpci_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: holds the request, term state, arithmetic units and the result register
    scpci_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .thr       (thr_reg),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

### tb/scpci_integral_checker.sv
// Watches the request, result and config channels of the sin*cos cell integral block,
// predicts every result and compares it. Depends on scpci_pkg.
`timescale 1ns / 1ps

module scpci_integral_checker
    import scpci_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  req_t              req,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  rsp_t              rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              pready,
    output int                fail_count,
    output int                awaiting
);

    localparam logic [63:0] TURNS_PER_RAD = 64'h28BE60DB9391054A;
    localparam longint      ROT_GAIN      = 652032874;
    localparam longint      DIFF_SAT      = 64'sd2147483648;
    localparam longint      SUM_HI        = 64'sd140737488355327;
    localparam longint      SUM_LO        = -64'sd140737488355328;

    typedef struct {
        longint kdiv;
        longint kmag;
        longint twice_cos;
        longint c0;
        longint c1;
    } freq_term_t;

    logic [THR_W-1:0] near_thr;
    rsp_t             integral_q[$];

    function automatic longint rot_angle(input int i);
        longint head[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                             33543516, 16775851, 8388437, 4194283, 2097149};
        if (i < 10)
            return head[i];
        if (i <= 30)
            return longint'(1) << (30 - i);
        return 0;
    endfunction

    // cos(|k|*|u|) in Q30 through the phase reduction and the fixed-step rotation
    function automatic longint cos_q30(input longint kmag, input longint u);
        logic [191:0] prod;
        logic [31:0]  turns;
        logic [63:0]  frac;
        longint       umag, x, y, z, dx, dy;
        umag = (u < 0) ? -u : u;
        prod = 192'(kmag) * 192'(umag) * 192'(TURNS_PER_RAD);
        turns = prod[103:72];
        frac = (64'(turns[29:0]) * 64'd1686629713) >> 30;
        x = ROT_GAIN;
        y = 0;
        z = longint'(frac);
        for (int i = 0; i < CORDIC_STEPS_DEF; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - rot_angle(i);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + rot_angle(i);
            end
        end
        case (turns[31:30])
            2'd0: return x;
            2'd1: return -y;
            2'd2: return -x;
            default: return y;
        endcase
    endfunction

    function automatic longint clamp_diff(input longint v);
        if (v > DIFF_SAT)
            return DIFF_SAT;
        if (v < -DIFF_SAT)
            return -DIFF_SAT;
        return v;
    endfunction

    function automatic void term_setup(inout freq_term_t tm, input longint k,
                                       input longint u0, input longint du);
        longint ca, cb, cc;
        tm.kdiv = k;
        tm.kmag = (k < 0) ? -k : k;
        ca = cos_q30(tm.kmag, u0);
        cb = cos_q30(tm.kmag, u0 + du);
        cc = cos_q30(tm.kmag, u0 + 2 * du);
        tm.c0 = clamp_diff(cb - ca);
        tm.c1 = clamp_diff(cc - cb);
        tm.twice_cos = 2 * cos_q30(tm.kmag, du);
    endfunction

    // Next cosine difference of one term, divided into its share of the integral
    function automatic longint term_share(inout freq_term_t tm, input int j);
        longint v;
        if (j == 0)
            v = tm.c0;
        else if (j == 1)
            v = tm.c1;
        else
        begin
            v = clamp_diff(((tm.twice_cos * tm.c1) >>> 30) - tm.c0);
            tm.c0 = tm.c1;
            tm.c1 = v;
        end
        if (tm.kdiv == 0)
            return 0;
        return -((v * 131072) / tm.kdiv);
    endfunction

    task automatic predict_cells(input req_t r);
        freq_term_t terms[2];
        longint     a1, a2, m1, m2, gap, sum;
        int         n, nterms;
        rsp_t       e;
        a1 = longint'(r.cos_frequency);
        a2 = longint'(r.sin_frequency);
        m1 = (a1 < 0) ? -a1 : a1;
        m2 = (a2 < 0) ? -a2 : a2;
        gap = (m1 > m2) ? m1 - m2 : m2 - m1;
        n = (r.cell_count > MAX_COUNT) ? MAX_COUNT : int'(r.cell_count);
        if (m2 <= longint'(near_thr))
            nterms = 0;
        else if (gap <= longint'(near_thr))
        begin
            nterms = 1;
            term_setup(terms[0], 2 * a2, r.start_point, r.step_size);
        end
        else
        begin
            nterms = 2;
            term_setup(terms[0], a2 - a1, r.start_point, r.step_size);
            term_setup(terms[1], a2 + a1, r.start_point, r.step_size);
        end
        for (int j = 0; j < n; j++)
        begin
            sum = 0;
            for (int t = 0; t < nterms; t++)
                sum += term_share(terms[t], j);
            if (sum > SUM_HI)
                sum = SUM_HI;
            if (sum < SUM_LO)
                sum = SUM_LO;
            e.integral_value = sum[47:0];
            e.cell_index = j[5:0];
            e.last_cell = (j + 1 == n);
            integral_q.push_back(e);
        end
    endtask

    initial
    begin
        fail_count = 0;
        awaiting = 0;
        near_thr = THR_RESET;
    end

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t e;
        if (!rst_n)
        begin
            near_thr = THR_RESET;
            integral_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && (paddr >> 2) == REG_NEAR_THR)
                near_thr = pwdata[THR_W-1:0];
            if (rsp_valid && rsp_ready)
            begin
                if (integral_q.size() == 0)
                begin
                    $error("unexpected result: index %0d value %0h",
                           rsp.cell_index, rsp.integral_value);
                    fail_count++;
                end
                else
                begin
                    e = integral_q.pop_front();
                    if (rsp.integral_value !== e.integral_value)
                    begin
                        $error("integral_value: expected %0d, got %0d",
                               e.integral_value, rsp.integral_value);
                        fail_count++;
                    end
                    if (rsp.cell_index !== e.cell_index)
                    begin
                        $error("cell_index: expected %0d, got %0d",
                               e.cell_index, rsp.cell_index);
                        fail_count++;
                    end
                    if (rsp.last_cell !== e.last_cell)
                    begin
                        $error("last_cell: expected %0d, got %0d",
                               e.last_cell, rsp.last_cell);
                        fail_count++;
                    end
                end
            end
            if (req_valid && req_ready)
                predict_cells(req);
        end
        awaiting = integral_q.size();
    end

endmodule

### tb/sin_cos_product_cell_integrals_top_test.sv
// Stimulus and verdict for the sin*cos cell integral block.
// Depends on scpci_pkg, sin_cos_product_cell_integrals_top and scpci_integral_checker.
`timescale 1ns / 1ps

module sin_cos_product_cell_integrals_top_test;
    import scpci_pkg::*;

    // Settle time after the last expected result: a zero-count request can still sit in
    // its load cycle when the queue runs dry; from the load state it goes straight back to idle.
    localparam int SETTLE_CYCLES = 2000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    req_t              req = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    rsp_t              rsp;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                fail_count;
    int                awaiting;
    int                burst_left = 0;
    int                stall_mode = 0;
    int                stall_timer = 0;

    sin_cos_product_cell_integrals_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    scpci_integral_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .awaiting   (awaiting)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver: switch between always ready, random stalls and long stalls every so often,
    // so that stalls land on every cell and on the last result of a request.
    always @(posedge clk)
    begin
        if (stall_timer == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_timer <= $urandom_range(20, 400);
        end
        else
            stall_timer <= stall_timer - 1;
        case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Hold one APB write through setup and access, then drop the select
    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Drop valid and wait until every predicted result has arrived and the block is idle
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Offer one request; keep valid high into the next request while the burst lasts
    task automatic send_request(input req_t r);
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (!req_ready);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 10);
            if ($urandom_range(0, 3) != 0)
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    endtask

    function automatic req_t make_request(input int kind);
        req_t r;
        int   pick;
        pick = $urandom_range(0, 99);
        r.start_point = ($urandom_range(0, 1) == 1) ? $urandom : $signed($urandom) >>> 6;
        r.step_size = ($urandom_range(0, 1) == 1) ? $urandom : $signed($urandom) >>> 10;
        if (pick < 4)
            r.cell_count = 7'd0;
        else if (pick < 9)
            r.cell_count = 7'($urandom_range(65, 127));
        else if (pick < 13)
            r.cell_count = 7'd64;
        else
            r.cell_count = 7'($urandom_range(1, 10));
        r.sin_frequency = ($urandom_range(0, 1) == 1) ? $urandom : $signed($urandom) >>> 12;
        case (kind)
            // near-equal magnitudes: one term, offset around the tolerance
            0: r.cos_frequency = (($urandom_range(0, 1) == 1) ? r.sin_frequency
                                  : -r.sin_frequency) + $signed($urandom_range(0, 16)) - 8;
            // sine frequency around zero
            1:
            begin
                r.sin_frequency = $signed($urandom_range(0, 16)) - 8;
                r.cos_frequency = $urandom;
            end
            default: r.cos_frequency = ($urandom_range(0, 1) == 1) ? $urandom
                                       : $signed($urandom) >>> 12;
        endcase
        return r;
    endfunction

    function automatic req_t pack_request(input int u0, input int du, input int n,
                                          input int a1, input int a2);
        req_t r;
        r.start_point = u0;
        r.step_size = du;
        r.cell_count = 7'(n);
        r.cos_frequency = a1;
        r.sin_frequency = a2;
        return r;
    endfunction

    initial
    begin
        logic [DATA_W-1:0] thr_list[5];
        thr_list = '{32'd0, 32'd65536, 32'h7FFF_FFFF, $urandom & 32'h7FFF_FFFF, 32'd7};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, all three cases, zero and oversized counts
        send_request(pack_request(0, 32'h0100_0000, 4, 32'h0001_0000, 32'h0002_0000));
        send_request(pack_request(32'h8000_0000, 32'h7FFF_FFFF, 3,
                                  32'h8000_0000, 32'h7FFF_FFFF));
        send_request(pack_request(32'h7FFF_FFFF, 32'h8000_0000, 3,
                                  32'h7FFF_FFFF, 32'h8000_0000));
        send_request(pack_request(32'h0080_0000, 32'h0010_0000, 1, 32'h0003_0000, 0));
        send_request(pack_request(32'h0080_0000, 32'h0010_0000, 2, 0, 7));
        send_request(pack_request(32'h0080_0000, 32'h0010_0000, 2, 0, -7));
        send_request(pack_request(32'h0080_0000, 32'h0010_0000, 2, 0, 8));
        send_request(pack_request(32'h0040_0000, 32'h0020_0000, 5, 32'h0005_0000,
                                  32'h0005_0000));
        send_request(pack_request(32'h0040_0000, 32'h0020_0000, 5, 32'hFFFB_0000,
                                  32'h0005_0000));
        send_request(pack_request(32'h0040_0000, 32'h0020_0000, 5, 32'h0005_0007,
                                  32'h0005_0000));
        send_request(pack_request(32'h0040_0000, 32'h0020_0000, 5, 32'h0005_0008,
                                  32'h0005_0000));
        send_request(pack_request(32'h0040_0000, 32'h0020_0000, 0, 32'h0001_0000,
                                  32'h0004_0000));
        send_request(pack_request(32'hFF00_0000, 32'h0004_0000, 64, 32'h0001_8000,
                                  32'h0003_0000));
        send_request(pack_request(32'h0100_0000, 32'hFFF0_0000, 127, 32'h0002_0000,
                                  32'hFFFF_0000));
        send_request(pack_request(0, 0, 65, 32'h0001_0000, 32'h0001_0001));
        send_request(pack_request(32'hFFFF_FFFF, 1, 6, 32'hFFFF_FFFF, 32'h0000_0001));
        send_request(pack_request(32'h1234_5678, 32'h0765_4321, 8, 32'h7FFF_FFFF,
                                  32'h7FFF_FFFF));
        send_request(pack_request(32'h0000_0001, 32'h7FFF_FFFF, 4, 32'h8000_0000,
                                  32'h8000_0001));

        // Pause the sender until the block has answered everything
        drain();

        // Random phases, each under its own tolerance
        foreach (thr_list[p])
        begin
            write_reg(ADDR_W'(REG_NEAR_THR) << 2, thr_list[p]);
            write_reg(3'd4, $urandom);
            @(posedge clk);
            repeat (60)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: send_request(make_request(0));
                    3: send_request(make_request(1));
                    default: send_request(make_request(2));
                endcase
            end
            drain();
        end

        if (fail_count == 0)
            $display("** sin_cos_product_cell_integrals_top: PASSED **");
        else
            $display("** sin_cos_product_cell_integrals_top: FAILED **");
        $finish;
    end

    // Give up long after the slowest correct run could end
    initial
    begin
        #40_000_000;
        $display("** sin_cos_product_cell_integrals_top: FAILED **");
        $finish;
    end

endmodule
